[src/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, command codes, verdict codes and the fixed reply strings of
// the modem response classifier.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int WIN_LEN = 10;
  localparam int NUM_PAT = 9;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [3:0] BREAKS_SHORT = 4'd4;
  localparam logic [3:0] BREAKS_LONG  = 4'd8;
  localparam logic [3:0] BREAKS_MAX   = 4'd15;

  typedef enum logic [2:0] {
    VERDICT_FAILURE    = 3'd0,
    VERDICT_OK         = 3'd1,
    VERDICT_REGISTERED = 3'd2,
    VERDICT_RING       = 3'd3,
    VERDICT_PROMPT     = 3'd4,
    VERDICT_NO_CARRIER = 3'd5
  } verdict_t;

  typedef logic [WIN_LEN-1:0][7:0] win_t;
  typedef logic [NUM_PAT-1:0] seen_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic [7:0] data;
  } match_ctl_t;

  localparam logic [7:0] PAT_TEXT [NUM_PAT][WIN_LEN] = '{
    '{"N", "O", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "U", "S", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "A", "N", "S", "W", "E", "R", 8'h00},
    '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R"},
    '{"C", "R", "E", "G", ":", " ", "0", ",", "1", 8'h00},
    '{"R", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam int PAT_LEN [NUM_PAT] = '{2, 2, 4, 5, 9, 10, 9, 4, 1};

  localparam verdict_t PAT_CODE [NUM_PAT] = '{
    VERDICT_FAILURE, VERDICT_OK, VERDICT_FAILURE, VERDICT_FAILURE,
    VERDICT_FAILURE, VERDICT_NO_CARRIER, VERDICT_REGISTERED, VERDICT_RING,
    VERDICT_PROMPT
  };

  // The newest byte sits at the top of the window, so a string ends there.
  function automatic logic pat_hit(win_t w, int p);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (i < PAT_LEN[p]) begin
        if (w[WIN_LEN - PAT_LEN[p] + i] != PAT_TEXT[p][i]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

  // Later strings in the list take priority over earlier ones.
  function automatic verdict_t pick_verdict(seen_t s);
    verdict_t v;
    v = VERDICT_FAILURE;
    for (int p = 0; p < NUM_PAT; p++) begin
      if (s[p]) begin
        v = PAT_CODE[p];
      end
    end
    return v;
  endfunction

endpackage

[src/modem_response_classifier.sv]
// ----------------------------------------------------------------------------
// modem_response_classifier
// Classifies a modem reply collected in a receive window into one verdict.
// ----------------------------------------------------------------------------
// A start transaction opens a window with a tick limit and a line-break mode;
// byte and tick transactions then feed it, and one verdict transaction leaves
// when the window closes on line breaks or on the tick limit, or at once on a
// start with a zero tick limit. Every input transaction is taken into an input
// register and handled against the window state once the output register is
// free, so one transaction is accepted per cycle while no verdict waits
// untaken, and the verdict is registered in the output register. No
// transaction is handled while a verdict waits untaken; the input register can
// still take one, and input stalls whenever a verdict waits while it holds one.
module modem_response_classifier
  import mrc_pkg::*;
#(
  parameter int BUFFER_BYTES = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_tick_limit,
  input  logic        in_long_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES);

  logic             item_valid_r;
  logic [1:0]       item_cmd_r;
  logic [7:0]       item_byte_r;
  logic [15:0]      item_limit_r;
  logic             item_mode_r;

  logic             active_r, active_nxt;
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [3:0]       breaks_r, breaks_nxt;
  logic [15:0]      ticks_r, ticks_nxt;
  logic [15:0]      limit_r, limit_nxt;
  logic             mode_r, mode_nxt;
  logic             ended_r, ended_nxt;

  logic             out_valid_r;
  verdict_t         out_verdict_r;

  logic             out_free;
  logic             proc_fire;
  logic             emit;
  logic [7:0]       stored_byte;
  match_ctl_t       mctl;
  verdict_t         verdict;

  assign out_free  = !out_valid_r || out_ready;
  assign proc_fire = item_valid_r && out_free;
  assign in_ready  = !item_valid_r || out_free;

  always_comb begin
    active_nxt  = active_r;
    stored_nxt  = stored_r;
    breaks_nxt  = breaks_r;
    ticks_nxt   = ticks_r;
    limit_nxt   = limit_r;
    mode_nxt    = mode_r;
    ended_nxt   = ended_r;
    emit        = 1'b0;
    mctl        = '0;
    stored_byte = item_byte_r;
    if (item_byte_r == CHAR_LF || item_byte_r == CHAR_CR) begin
      stored_byte = CHAR_SPACE;
    end
    mctl.data = stored_byte;
    if (proc_fire) begin
      case (item_cmd_r)
        CMD_START: begin
          mctl.clear = 1'b1;
          stored_nxt = '0;
          breaks_nxt = '0;
          ticks_nxt  = '0;
          ended_nxt  = 1'b0;
          limit_nxt  = item_limit_r;
          mode_nxt   = item_mode_r;
          emit       = (item_limit_r == '0);
          active_nxt = !emit;
        end
        CMD_BYTE: begin
          if (active_r) begin
            if (stored_r < CNT_MAX) begin
              stored_nxt = stored_r + 1'b1;
              if (stored_byte == CHAR_SPACE && item_byte_r != CHAR_SPACE
                  && breaks_r < BREAKS_MAX) begin
                breaks_nxt = breaks_r + 1'b1;
              end
              if (!ended_r) begin
                if (stored_byte == CHAR_NUL) begin
                  ended_nxt = 1'b1;
                end else begin
                  mctl.push = 1'b1;
                end
              end
            end
            emit = (!mode_r && breaks_nxt == BREAKS_SHORT)
                || (mode_r && breaks_nxt == BREAKS_LONG);
            active_nxt = !emit;
          end
        end
        CMD_TICK: begin
          if (active_r) begin
            if (ticks_r != 16'hFFFF) begin
              ticks_nxt = ticks_r + 1'b1;
            end
            emit       = (ticks_nxt >= limit_r);
            active_nxt = !emit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  mrc_matcher u_matcher (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd_r   <= in_cmd;
      item_byte_r  <= in_data_byte;
      item_limit_r <= in_tick_limit;
      item_mode_r  <= in_long_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      stored_r <= '0;
      breaks_r <= '0;
      ticks_r  <= '0;
      limit_r  <= '0;
      mode_r   <= 1'b0;
      ended_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      stored_r <= stored_nxt;
      breaks_r <= breaks_nxt;
      ticks_r  <= ticks_nxt;
      limit_r  <= limit_nxt;
      mode_r   <= mode_nxt;
      ended_r  <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // A start with a zero tick limit must produce a verdict right away.
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && item_cmd_r == CMD_START && item_limit_r == '0) |=> out_valid_r)
    else $error("zero tick limit start did not produce a verdict");

  // A verdict always closes the window.
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && emit) |=> !active_r)
    else $error("window still open after a verdict");

  // An open window never holds the line breaks that should have closed it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !mode_r) |-> (breaks_r < BREAKS_SHORT))
    else $error("short mode window open past its line-break limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && mode_r) |-> (breaks_r < BREAKS_LONG))
    else $error("long mode window open past its line-break limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CNT_MAX)
    else $error("stored byte count exceeds the buffer size");

endmodule

[src/mrc_matcher.sv]
// ----------------------------------------------------------------------------
// mrc_matcher
// Keeps the last ten text bytes and one seen flag per reply string, and gives
// the verdict that the flags will hold after the current update.
// ----------------------------------------------------------------------------
module mrc_matcher
  import mrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  match_ctl_t ctl,
  output verdict_t   verdict
);

  win_t  win_r;
  win_t  win_nxt;
  seen_t seen_r;
  seen_t seen_nxt;
  win_t  shifted;

  always_comb begin
    shifted = {ctl.data, win_r[WIN_LEN-1:1]};
    win_nxt  = win_r;
    seen_nxt = seen_r;
    if (ctl.clear) begin
      win_nxt  = '0;
      seen_nxt = '0;
    end else if (ctl.push) begin
      win_nxt = shifted;
      for (int p = 0; p < NUM_PAT; p++) begin
        if (pat_hit(shifted, p)) begin
          seen_nxt[p] = 1'b1;
        end
      end
    end
  end

  assign verdict = pick_verdict(seen_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      seen_r <= '0;
    end else begin
      win_r  <= win_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule
